// ----- rtl/core/ird_pkg.sv -----
// ----------------------------------------------------------------------------
// ird_pkg
// Shared types and constants for the IIR, rectifier and derivative core.
// ----------------------------------------------------------------------------
package ird_pkg;

  localparam int X_W       = 16;  // sample and result width
  localparam int COEF_W    = 18;  // signed Q4.14 coefficient
  localparam int FRAC_W    = 14;
  localparam int ACC_W     = 40;  // delay words and full-precision output
  localparam int MUL_B_W   = 21;  // second multiplier operand
  localparam int HALF_W    = 20;  // split of the 40-bit output into two halves
  localparam int PROD_W    = COEF_W + MUL_B_W;
  localparam int SUM_W     = 61;  // feedback accumulator
  localparam int MAX_ORDER = 3;
  localparam int IDX_W     = 2;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLARITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B0       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B1       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B2       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B3       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_A1       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_A2       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_A3       = 3'd7;

  localparam logic signed [COEF_W-1:0] B0_RESET = 18'sd16384;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // multiplier operations
  typedef enum logic [1:0] {
    OP_BX,   // b[i] * sample
    OP_AYH,  // a[i] * upper half of output
    OP_AYL   // a[i] * lower half of output
  } op_t;

  typedef struct packed {
    logic             load_x;
    logic             mul_go;
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             finish;
  } cmd_t;

endpackage

// ----- rtl/core/ird_ctrl.sv -----
// ----------------------------------------------------------------------------
// ird_ctrl
// Sequencer: steps the shared multiplier through the filter terms of one item.
// ----------------------------------------------------------------------------
module ird_ctrl #(
  parameter int ORDER = 3
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ird_pkg::cmd_t cmd_o
);

  ird_pkg::state_t                state_r, state_nxt;
  ird_pkg::op_t                   op_r, op_nxt;
  logic [ird_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ird_pkg::cmd_t                  cmd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ird_pkg::ST_IDLE;
      op_r        <= ird_pkg::OP_BX;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    idx_nxt   = idx_r;
    cmd_c     = '0;
    cmd_c.op  = op_r;
    cmd_c.idx = idx_r;
    case (state_r)
      ird_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_c.load_x = 1'b1;
          state_nxt    = ird_pkg::ST_RUN;
          op_nxt       = ird_pkg::OP_BX;
          idx_nxt      = '0;
        end
      end
      ird_pkg::ST_RUN: begin
        cmd_c.mul_go = 1'b1;
        case (op_r)
          ird_pkg::OP_BX: begin
            // b0 first, then b1 so that its partial sum is ready before a1
            if (idx_r == '0) begin
              idx_nxt = idx_r + 1'b1;
            end else begin
              op_nxt = ird_pkg::OP_AYH;
            end
          end
          ird_pkg::OP_AYH: begin
            op_nxt = ird_pkg::OP_AYL;
          end
          ird_pkg::OP_AYL: begin
            if (idx_r == ird_pkg::IDX_W'(ORDER)) begin
              state_nxt = ird_pkg::ST_DRAIN;
            end else begin
              op_nxt  = ird_pkg::OP_BX;
              idx_nxt = idx_r + 1'b1;
            end
          end
          default: begin
            state_nxt = ird_pkg::ST_IDLE;
          end
        endcase
      end
      ird_pkg::ST_DRAIN: begin
        state_nxt = ird_pkg::ST_DONE;
      end
      ird_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd_c.finish = 1'b1;
          state_nxt    = ird_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ird_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd_c.finish | (out_valid_r & out_stall);
  end

  assign cmd_o     = cmd_c;
  assign in_stall  = (state_r != ird_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ird_pkg::ST_RUN))
    else $error("accepted beat did not start the sequence");

  a_finish_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_c.finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a beat still waiting");

  a_drain_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ird_pkg::ST_DRAIN) |-> $past(cmd_c.mul_go))
    else $error("drain entered without a final multiply");

endmodule

// ----- rtl/core/ird_dp.sv -----
// ----------------------------------------------------------------------------
// ird_dp
// Datapath: registers, shared 18x21 multiplier, accumulator and output stage.
// ----------------------------------------------------------------------------
module ird_dp #(
  parameter int ORDER = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [ird_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ird_pkg::COEF_W-1:0]             cfg_data,
  input  logic signed [ird_pkg::X_W-1:0]         in_sample_in,
  input  ird_pkg::cmd_t                          cmd_i,
  output logic signed [ird_pkg::X_W-1:0]         out_filtered_out,
  output logic signed [ird_pkg::X_W-1:0]         out_rectified_out,
  output logic signed [ird_pkg::X_W-1:0]         out_derivative_out,
  output logic                                   out_derivative_valid
);

  localparam int ACC_W  = ird_pkg::ACC_W;
  localparam int PROD_W = ird_pkg::PROD_W;
  localparam int SUM_W  = ird_pkg::SUM_W;
  localparam int FRAC_W = ird_pkg::FRAC_W;
  localparam int X_W    = ird_pkg::X_W;
  localparam int HALF_W = ird_pkg::HALF_W;

  logic                               pol_r;
  logic signed [ird_pkg::COEF_W-1:0]  b_r [ird_pkg::MAX_ORDER+1];
  logic signed [ird_pkg::COEF_W-1:0]  a_r [ird_pkg::MAX_ORDER];
  logic signed [ACC_W-1:0]            d_r [ird_pkg::MAX_ORDER];
  logic signed [X_W-1:0]              hist0_r, hist1_r;
  logic [1:0]                         cnt_r;

  logic signed [X_W-1:0]              x_r;
  logic signed [PROD_W-1:0]           prod_r;
  logic                               acc_vld_r;
  ird_pkg::op_t                       acc_op_r;
  logic [ird_pkg::IDX_W-1:0]          acc_idx_r;
  logic signed [ACC_W-1:0]            y_r;
  logic signed [ACC_W:0]              t_r;
  logic signed [SUM_W-1:0]            acc_r;
  logic signed [X_W-1:0]              filt_r;

  logic signed [ird_pkg::COEF_W-1:0]  mul_a;
  logic signed [ird_pkg::MUL_B_W-1:0] mul_b;
  logic signed [ACC_W:0]              prod_ext;
  logic signed [ACC_W:0]              y_sum;
  logic signed [ACC_W-1:0]            y_nxt;
  logic signed [ACC_W-1:0]            d_next_in;
  logic signed [ACC_W:0]              t_nxt;
  logic signed [SUM_W-1:0]            acc_nxt;
  logic signed [SUM_W-1:0]            fb_sum;
  logic signed [ACC_W-1:0]            d_new;
  logic signed [ACC_W:0]              y_round;
  logic signed [ACC_W-FRAC_W:0]       y_int;
  logic signed [X_W-1:0]              filt_nxt;
  logic signed [X_W-1:0]              rect;
  logic signed [X_W:0]                diff;
  logic signed [X_W:0]                half;
  logic                               dvalid;

  // multiplier operand selection
  always_comb begin
    case (cmd_i.idx)
      2'd1:    mul_a = (cmd_i.op == ird_pkg::OP_BX) ? b_r[1] : a_r[0];
      2'd2:    mul_a = (cmd_i.op == ird_pkg::OP_BX) ? b_r[2] : a_r[1];
      2'd3:    mul_a = (cmd_i.op == ird_pkg::OP_BX) ? b_r[3] : a_r[2];
      default: mul_a = b_r[0];
    endcase
    case (cmd_i.op)
      ird_pkg::OP_AYH: mul_b = {y_r[ACC_W-1], y_r[ACC_W-1:HALF_W]};
      ird_pkg::OP_AYL: mul_b = {1'b0, y_r[HALF_W-1:0]};
      default:         mul_b = {{(ird_pkg::MUL_B_W-X_W){x_r[X_W-1]}}, x_r};
    endcase
  end

  assign prod_ext = {{(ACC_W+1-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // y = sat40(b0*x + d0)
  assign y_sum = prod_ext + {d_r[0][ACC_W-1], d_r[0]};
  always_comb begin
    if (y_sum[ACC_W] != y_sum[ACC_W-1]) begin
      y_nxt = y_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      y_nxt = y_sum[ACC_W-1:0];
    end
  end

  // partial sum b[i]*x + d[i], the next word counts only below the top order
  always_comb begin
    case (acc_idx_r)
      2'd1:    d_next_in = d_r[1];
      2'd2:    d_next_in = d_r[2];
      default: d_next_in = '0;
    endcase
    if (acc_idx_r >= ird_pkg::IDX_W'(ORDER)) begin
      d_next_in = '0;
    end
  end
  assign t_nxt = prod_ext + {d_next_in[ACC_W-1], d_next_in};

  // t - floor((a*y + 2^13) / 2^14) == floor((t*2^14 - a*y + 2^13 - 1) / 2^14)
  assign acc_nxt = $signed({{(SUM_W-ACC_W-1-FRAC_W){t_r[ACC_W]}}, t_r,
                            {1'b0, {(FRAC_W-1){1'b1}}}})
                 - $signed({{(SUM_W-PROD_W-HALF_W){prod_r[PROD_W-1]}}, prod_r,
                            {HALF_W{1'b0}}});
  assign fb_sum  = acc_r - $signed({{(SUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  always_comb begin
    if (fb_sum[SUM_W-1:FRAC_W+ACC_W-1] != {(SUM_W-FRAC_W-ACC_W+1){fb_sum[SUM_W-1]}}) begin
      d_new = fb_sum[SUM_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      d_new = fb_sum[FRAC_W+ACC_W-1:FRAC_W];
    end
  end

  // output rounding, half up, then saturation to 16 bits
  assign y_round = {y_r[ACC_W-1], y_r} + $signed((ACC_W+1)'(1) <<< (FRAC_W-1));
  assign y_int   = y_round[ACC_W:FRAC_W];
  always_comb begin
    if (y_int[ACC_W-FRAC_W:X_W-1] != {(ACC_W-FRAC_W-X_W+2){y_int[ACC_W-FRAC_W]}}) begin
      filt_nxt = y_int[ACC_W-FRAC_W] ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}};
    end else begin
      filt_nxt = y_int[X_W-1:0];
    end
  end

  // rectify and central difference, halved toward zero
  always_comb begin
    if (pol_r) begin
      rect = (filt_r > 0) ? '0 : filt_r;
    end else begin
      rect = (filt_r < 0) ? '0 : filt_r;
    end
    diff   = {rect[X_W-1], rect} - {hist1_r[X_W-1], hist1_r};
    half   = (diff + $signed({{X_W{1'b0}}, diff[X_W]})) >>> 1;
    dvalid = (cnt_r >= 2'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r     <= 1'b0;
      b_r[0]    <= ird_pkg::B0_RESET;
      b_r[1]    <= '0;
      b_r[2]    <= '0;
      b_r[3]    <= '0;
      a_r[0]    <= '0;
      a_r[1]    <= '0;
      a_r[2]    <= '0;
      d_r[0]    <= '0;
      d_r[1]    <= '0;
      d_r[2]    <= '0;
      hist0_r   <= '0;
      hist1_r   <= '0;
      cnt_r     <= '0;
      acc_vld_r <= 1'b0;
    end else begin
      acc_vld_r <= cmd_i.mul_go;
      if (cfg_wr_en) begin
        case (cfg_index)
          ird_pkg::REG_POLARITY: pol_r  <= cfg_data[0];
          ird_pkg::REG_B0:       b_r[0] <= cfg_data;
          ird_pkg::REG_B1:       b_r[1] <= cfg_data;
          ird_pkg::REG_B2:       b_r[2] <= cfg_data;
          ird_pkg::REG_B3:       b_r[3] <= cfg_data;
          ird_pkg::REG_A1:       a_r[0] <= cfg_data;
          ird_pkg::REG_A2:       a_r[1] <= cfg_data;
          ird_pkg::REG_A3:       a_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (acc_vld_r && acc_op_r == ird_pkg::OP_AYL) begin
        case (acc_idx_r)
          2'd1:    d_r[0] <= d_new;
          2'd2:    d_r[1] <= d_new;
          2'd3:    d_r[2] <= d_new;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        hist1_r <= hist0_r;
        hist0_r <= rect;
        if (cnt_r != 2'd3) begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    filt_r <= filt_nxt;
    if (cmd_i.load_x) begin
      x_r <= in_sample_in;
    end
    if (cmd_i.mul_go) begin
      prod_r    <= mul_a * mul_b;
      acc_op_r  <= cmd_i.op;
      acc_idx_r <= cmd_i.idx;
    end
    if (acc_vld_r) begin
      case (acc_op_r)
        ird_pkg::OP_BX: begin
          if (acc_idx_r == '0) begin
            y_r <= y_nxt;
          end else begin
            t_r <= t_nxt;
          end
        end
        ird_pkg::OP_AYH: acc_r <= acc_nxt;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      out_filtered_out     <= filt_r;
      out_rectified_out    <= rect;
      out_derivative_out   <= dvalid ? half[X_W-1:0] : '0;
      out_derivative_valid <= dvalid;
    end
  end

  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd3) |=> (cnt_r == 2'd3))
    else $error("sample count left saturation");

endmodule

// ----- rtl/core/iir_rectify_derivative_core.sv -----
// ----------------------------------------------------------------------------
// iir_rectify_derivative_core
// IIR filter, half-wave rectifier and central difference on one sample a beat.
// ----------------------------------------------------------------------------
// sequence: accept, 1 + 3*ORDER multiplier products, DRAIN, then DONE (held while
//   an earlier beat is stalled), then out_valid; one sample at a time, as the
//   single shared 18x21 multiplier does all products of a sample
// a finished beat waits in the output register while the next sample is taken
// reset (synchronous, rst_n low): filter state, history and count cleared,
//   b0 = 1.0, other coefficients and polarity zero
// ----------------------------------------------------------------------------
module iir_rectify_derivative_core #(
  parameter int ORDER = 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [ird_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ird_pkg::COEF_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ird_pkg::X_W-1:0]         in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ird_pkg::X_W-1:0]         out_filtered_out,
  output logic signed [ird_pkg::X_W-1:0]         out_rectified_out,
  output logic signed [ird_pkg::X_W-1:0]         out_derivative_out,
  output logic                                   out_derivative_valid
);

  ird_pkg::cmd_t cmd;

  ird_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd)
  );

  ird_dp #(
    .ORDER (ORDER)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_sample_in         (in_sample_in),
    .cmd_i                (cmd),
    .out_filtered_out     (out_filtered_out),
    .out_rectified_out    (out_rectified_out),
    .out_derivative_out   (out_derivative_out),
    .out_derivative_valid (out_derivative_valid)
  );

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for iir_rectify_derivative_core: a directed part covers
// reset coefficients, start-up of the derivative, polarity change mid-stream
// and filter overflow, then randomised phases sweep the coefficient space.
// Each sample is predicted on acceptance and compared beat by beat.
// ----------------------------------------------------------------------------
module testbench;
  import ird_pkg::*;

  localparam int     FILTER_ORDER = 3;
  localparam int     DRAIN_CYCLES = 2 * (3 + 3 * FILTER_ORDER);
  localparam longint ROUND_HALF   = 64'sd8192;
  localparam longint ACC_TOP      = 64'sd549755813887;
  localparam longint ACC_BOTTOM   = -ACC_TOP - 1;
  localparam int     PHASE_BEATS  = 92;

  // kinds of coefficient set for the random phases
  localparam int SET_MAX    = 0;
  localparam int SET_MIN    = 1;
  localparam int SET_STABLE = 2;
  localparam int SET_WILD   = 3;

  typedef struct {
    logic signed [X_W-1:0] filt;
    logic signed [X_W-1:0] rect;
    logic signed [X_W-1:0] deriv;
    logic                  dvalid;
  } ecg_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = REG_POLARITY;
  logic [COEF_W-1:0]            cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [X_W-1:0]        in_sample_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [X_W-1:0]        out_filtered_out;
  logic signed [X_W-1:0]        out_rectified_out;
  logic signed [X_W-1:0]        out_derivative_out;
  logic                         out_derivative_valid;

  // predictor copy of registers and filter state
  logic                         pol_neg;
  logic signed [COEF_W-1:0]     b_coef [0:MAX_ORDER];
  logic signed [COEF_W-1:0]     a_coef [1:MAX_ORDER];
  longint                       delay_word [0:MAX_ORDER-1];
  logic signed [X_W-1:0]        rect_prev [0:1];
  int                           seen_count;

  ecg_result_t                  expected_beats [$];
  int                           errors = 0;
  int                           beats_checked = 0;
  int                           samples_sent = 0;
  int                           settings_used = 0;
  bit                           gaps_on = 1'b1;
  bit                           stall_on = 1'b1;

  iir_rectify_derivative_core #(
    .ORDER(FILTER_ORDER)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_in        (in_sample_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_out    (out_filtered_out),
    .out_rectified_out   (out_rectified_out),
    .out_derivative_out  (out_derivative_out),
    .out_derivative_valid(out_derivative_valid)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint sat40(longint v);
    if (v > ACC_TOP) return ACC_TOP;
    if (v < ACC_BOTTOM) return ACC_BOTTOM;
    return v;
  endfunction

  function automatic logic signed [X_W-1:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  // transposed direct form II, rectifier and central difference on one sample
  function automatic ecg_result_t filter_sample(logic signed [X_W-1:0] sample);
    ecg_result_t res;
    longint      xs;
    longint      y_full;
    longint      fb;
    longint      nxt;
    xs = longint'(sample);
    y_full = sat40(longint'(b_coef[0]) * xs + delay_word[0]);
    for (int i = 1; i <= FILTER_ORDER; i++) begin
      fb = (longint'(a_coef[i]) * y_full + ROUND_HALF) >>> FRAC_W;
      nxt = (i < FILTER_ORDER) ? delay_word[i] : 64'sd0;
      delay_word[i-1] = sat40(longint'(b_coef[i]) * xs + nxt - fb);
    end
    res.filt = sat16((y_full + ROUND_HALF) >>> FRAC_W);
    if (pol_neg) begin
      res.rect = (res.filt > 0) ? 16'sd0 : res.filt;
    end else begin
      res.rect = (res.filt < 0) ? 16'sd0 : res.filt;
    end
    if (seen_count < 3) seen_count++;
    res.dvalid = (seen_count >= 3);
    res.deriv = res.dvalid ? 16'((int'(res.rect) - int'(rect_prev[1])) / 2) : 16'sd0;
    rect_prev[1] = rect_prev[0];
    rect_prev[0] = res.rect;
    return res;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [X_W-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 16'sh7fff;
    if (r < 10) return 16'sh8000;
    if (r < 40) return 16'($urandom_range(0, 511) - 256);
    return 16'($urandom());
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(int lo, int hi);
    return COEF_W'($urandom_range(0, hi - lo) + lo);
  endfunction

  task automatic reset_predictor();
    pol_neg = 1'b0;
    for (int i = 0; i <= MAX_ORDER; i++) b_coef[i] = '0;
    for (int i = 1; i <= MAX_ORDER; i++) a_coef[i] = '0;
    b_coef[0] = B0_RESET;
    for (int i = 0; i < MAX_ORDER; i++) delay_word[i] = 0;
    rect_prev[0] = '0;
    rect_prev[1] = '0;
    seen_count = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_POLARITY: pol_neg = data[0];
      REG_B0:       b_coef[0] = data;
      REG_B1:       b_coef[1] = data;
      REG_B2:       b_coef[2] = data;
      REG_B3:       b_coef[3] = data;
      REG_A1:       a_coef[1] = data;
      REG_A2:       a_coef[2] = data;
      REG_A3:       a_coef[3] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high across back-to-back beats, dropped only before a gap
  task automatic send_sample(logic signed [X_W-1:0] s);
    int gap;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_beats.insert(expected_beats.size(), filter_sample(s));
    samples_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      errors++;
    end
  endtask

  // receiver back-pressure
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (!stall_on) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        hold = gap_len();
      end else begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin
    ecg_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected, filtered %0d", $time,
                 out_filtered_out);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        check_field("filtered_out", want.filt, out_filtered_out);
        check_field("rectified_out", want.rect, out_rectified_out);
        check_field("derivative_out", want.deriv, out_derivative_out);
        check_field("derivative_valid", want.dvalid, out_derivative_valid);
        beats_checked++;
      end
    end
  end

  // reset coefficients pass the sample through; derivative invalid for two beats
  task automatic test_reset_passthrough();
    logic signed [X_W-1:0] seq [7];
    seq = '{16'sh7fff, 16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sd12345, -16'sd12345};
    settings_used++;
    foreach (seq[i]) send_sample(seq[i]);
    wait_idle();
  endtask

  // history keeps its old rectification after the polarity flips
  task automatic test_polarity_switch();
    write_reg(REG_POLARITY, 18'd1);
    settings_used++;
    send_sample(-16'sd200);
    send_sample(16'sd300);
    send_sample(16'sh8000);
    send_sample(16'sd5);
    wait_idle();
  endtask

  // large gain and strong feedback drive the delay words into saturation
  task automatic test_overflow();
    write_reg(REG_B0, 18'sh1ffff);
    write_reg(REG_B1, 18'sh1ffff);
    write_reg(REG_A1, 18'sh20000);
    write_reg(REG_POLARITY, 18'd0);
    settings_used++;
    repeat (4) send_sample(16'sh7fff);
    repeat (3) send_sample(16'sh8000);
    repeat (2) send_sample(16'sd0);
    wait_idle();
  endtask

  task automatic load_coef_set(int kind);
    logic [COEF_W-1:0] val;
    write_reg(REG_POLARITY, COEF_W'($urandom_range(0, 1)));
    for (int r = REG_B0; r <= REG_A3; r++) begin
      case (kind)
        SET_MAX:    val = 18'sh1ffff;
        SET_MIN:    val = 18'sh20000;
        SET_STABLE: val = (r <= REG_B3) ? rand_coef(-16384, 16384) : rand_coef(-4000, 4000);
        default:    val = COEF_W'($urandom());
      endcase
      write_reg(CFG_IDX_W'(r), val);
    end
    settings_used++;
  endtask

  task automatic test_random_phases();
    int kind;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) kind = SET_MAX;
      else if (phase == 1) kind = SET_MIN;
      else if (phase == 5) kind = SET_WILD;
      else kind = SET_STABLE;
      load_coef_set(kind);
      // alternate idle patterns, including stretches with none
      gaps_on  = phase[0];
      stall_on = phase[1];
      repeat (PHASE_BEATS) send_sample(rand_sample());
      wait_idle();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_passthrough();
    test_polarity_switch();
    test_overflow();
    test_random_phases();
    wait_idle();
    $display("%0d samples sent, %0d result beats checked", samples_sent, beats_checked);
    $display("across %0d register settings, extremes and overflow included", settings_used);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- iir_rectify_derivative_core.f -----
rtl/core/ird_pkg.sv
rtl/core/ird_ctrl.sv
rtl/core/ird_dp.sv
rtl/core/iir_rectify_derivative_core.sv
tb/testbench.sv
